FILE: hw/rtl/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg: shared types and widths for the quaternion vector rotator
// Holds the quaternion, vector and intermediate product types that travel
// between the two product stages.
// ----------------------------------------------------------------------------
package qvr_pkg;

	localparam int unsigned CompW = 16;   // input and output component width
	localparam int unsigned FracW = 15;   // Q1.15 fraction bits
	localparam int unsigned TW    = 18;   // first product component width

	typedef struct packed {
		logic signed [CompW-1:0] x;
		logic signed [CompW-1:0] y;
		logic signed [CompW-1:0] z;
		logic signed [CompW-1:0] w;
	} qvr_quat_t;

	typedef struct packed {
		logic signed [CompW-1:0] x;
		logic signed [CompW-1:0] y;
		logic signed [CompW-1:0] z;
	} qvr_vec_t;

	typedef struct packed {
		logic signed [TW-1:0] x;
		logic signed [TW-1:0] y;
		logic signed [TW-1:0] z;
		logic signed [TW-1:0] w;
	} qvr_tquat_t;

endpackage

FILE: hw/rtl/qvr_fwd_mul.sv
// ----------------------------------------------------------------------------
// qvr_fwd_mul: first Hamilton product t = q * (v, 0)
// Two register stages: twelve 16x16 products, then rounded sums of three.
// ----------------------------------------------------------------------------
module qvr_fwd_mul
	import qvr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  qvr_quat_t  quat,
	input  qvr_vec_t   vec,
	output logic       t_valid,
	output qvr_tquat_t t_quat,
	output qvr_quat_t  t_rot
);

	localparam int unsigned PW = 2 * CompW;   // product width
	localparam int unsigned SW = PW + 2;      // sum width with rounding headroom
	localparam logic signed [SW-1:0] Half = SW'(1) <<< (FracW - 1);

	logic                 valid_s1;
	qvr_quat_t            quat_s1;
	logic signed [PW-1:0] p_wx_s1, p_yz_s1, p_zy_s1;
	logic signed [PW-1:0] p_wy_s1, p_xz_s1, p_zx_s1;
	logic signed [PW-1:0] p_wz_s1, p_xy_s1, p_yx_s1;
	logic signed [PW-1:0] p_xx_s1, p_yy_s1, p_zz_s1;

	logic                 valid_s2;
	qvr_tquat_t           t_s2;
	qvr_quat_t            quat_s2;

	logic signed [SW-1:0] sx, sy, sz, sw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1: all partial products in parallel
	always_ff @(posedge clk) begin
		quat_s1 <= quat;
		p_wx_s1 <= quat.w * vec.x;
		p_yz_s1 <= quat.y * vec.z;
		p_zy_s1 <= quat.z * vec.y;
		p_wy_s1 <= quat.w * vec.y;
		p_xz_s1 <= quat.x * vec.z;
		p_zx_s1 <= quat.z * vec.x;
		p_wz_s1 <= quat.w * vec.z;
		p_xy_s1 <= quat.x * vec.y;
		p_yx_s1 <= quat.y * vec.x;
		p_xx_s1 <= quat.x * vec.x;
		p_yy_s1 <= quat.y * vec.y;
		p_zz_s1 <= quat.z * vec.z;
	end

	// Stage 2: sum, add half an LSB, drop the fraction bits
	always_comb begin
		sx = SW'(p_wx_s1) + SW'(p_yz_s1) - SW'(p_zy_s1) + Half;
		sy = SW'(p_wy_s1) - SW'(p_xz_s1) + SW'(p_zx_s1) + Half;
		sz = SW'(p_wz_s1) + SW'(p_xy_s1) - SW'(p_yx_s1) + Half;
		sw = Half - SW'(p_xx_s1) - SW'(p_yy_s1) - SW'(p_zz_s1);
	end

	always_ff @(posedge clk) begin
		quat_s2 <= quat_s1;
		t_s2.x  <= sx[FracW+TW-1:FracW];
		t_s2.y  <= sy[FracW+TW-1:FracW];
		t_s2.z  <= sz[FracW+TW-1:FracW];
		t_s2.w  <= sw[FracW+TW-1:FracW];
	end

	assign t_valid = valid_s2;
	assign t_quat  = t_s2;
	assign t_rot   = quat_s2;

endmodule

FILE: hw/rtl/qvr_conj_mul.sv
// ----------------------------------------------------------------------------
// qvr_conj_mul: second Hamilton product r = t * conj(q) and saturation
// Two register stages: twelve 18x16 products, then rounded sums of four,
// clamped to 16 bits with a clip flag.
// ----------------------------------------------------------------------------
module qvr_conj_mul
	import qvr_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    t_valid,
	input  qvr_tquat_t              t_quat,
	input  qvr_quat_t               t_rot,
	output logic                    r_valid,
	output logic signed [CompW-1:0] r_x,
	output logic signed [CompW-1:0] r_y,
	output logic signed [CompW-1:0] r_z,
	output logic                    r_clip
);

	localparam int unsigned PW = TW + CompW - 1;   // product width
	localparam int unsigned SW = PW + 3;           // sum of four plus rounding
	localparam int unsigned RW = SW - FracW;       // width after scaling
	localparam logic signed [SW-1:0] Half = SW'(1) <<< (FracW - 1);
	localparam logic signed [RW-1:0] MaxV = RW'((1 << (CompW - 1)) - 1);
	localparam logic signed [RW-1:0] MinV = -RW'(1 << (CompW - 1));

	logic                 valid_s3;
	logic signed [PW-1:0] a_x_s3, b_x_s3, c_x_s3, d_x_s3;
	logic signed [PW-1:0] a_y_s3, b_y_s3, c_y_s3, d_y_s3;
	logic signed [PW-1:0] a_z_s3, b_z_s3, c_z_s3, d_z_s3;

	logic                    valid_s4;
	logic signed [CompW-1:0] x_s4, y_s4, z_s4;
	logic                    clip_s4;

	logic signed [SW-1:0] sx, sy, sz;
	logic signed [RW-1:0] rx, ry, rz;
	logic                 hi_x, lo_x, hi_y, lo_y, hi_z, lo_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= t_valid;
			valid_s4 <= valid_s3;
		end
	end

	// Stage 3: products of t with the quaternion
	always_ff @(posedge clk) begin
		a_x_s3 <= t_quat.w * t_rot.x;
		b_x_s3 <= t_quat.x * t_rot.w;
		c_x_s3 <= t_quat.y * t_rot.z;
		d_x_s3 <= t_quat.z * t_rot.y;
		a_y_s3 <= t_quat.w * t_rot.y;
		b_y_s3 <= t_quat.x * t_rot.z;
		c_y_s3 <= t_quat.y * t_rot.w;
		d_y_s3 <= t_quat.z * t_rot.x;
		a_z_s3 <= t_quat.w * t_rot.z;
		b_z_s3 <= t_quat.x * t_rot.y;
		c_z_s3 <= t_quat.y * t_rot.x;
		d_z_s3 <= t_quat.z * t_rot.w;
	end

	// Stage 4: signs follow the conjugate, then round and clamp
	always_comb begin
		sx = SW'(b_x_s3) - SW'(a_x_s3) - SW'(c_x_s3) + SW'(d_x_s3) + Half;
		sy = SW'(b_y_s3) - SW'(a_y_s3) + SW'(c_y_s3) - SW'(d_y_s3) + Half;
		sz = SW'(c_z_s3) - SW'(a_z_s3) - SW'(b_z_s3) + SW'(d_z_s3) + Half;
		rx = sx[SW-1:FracW];
		ry = sy[SW-1:FracW];
		rz = sz[SW-1:FracW];
		hi_x = rx > MaxV;
		lo_x = rx < MinV;
		hi_y = ry > MaxV;
		lo_y = ry < MinV;
		hi_z = rz > MaxV;
		lo_z = rz < MinV;
	end

	always_ff @(posedge clk) begin
		x_s4    <= hi_x ? MaxV[CompW-1:0] : (lo_x ? MinV[CompW-1:0] : rx[CompW-1:0]);
		y_s4    <= hi_y ? MaxV[CompW-1:0] : (lo_y ? MinV[CompW-1:0] : ry[CompW-1:0]);
		z_s4    <= hi_z ? MaxV[CompW-1:0] : (lo_z ? MinV[CompW-1:0] : rz[CompW-1:0]);
		clip_s4 <= hi_x | lo_x | hi_y | lo_y | hi_z | lo_z;
	end

	assign r_valid = valid_s4;
	assign r_x     = x_s4;
	assign r_y     = y_s4;
	assign r_z     = z_s4;
	assign r_clip  = clip_s4;

endmodule

FILE: hw/rtl/quaternion_vector_rotate_top.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_top: fixed-point rotation of a vector by a quaternion
// Computes the vector part of q * (v, 0) * conj(q) with Q1.15 rounding after
// each product and 16-bit saturation of the result.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                  Transfer
//  --------  ---------------------------------------  --------------------------
//  input     start, busy, quat_x/y/z/w, vec_x/y/z     start high, busy low
//  result    done, out_x, out_y, out_z, clipped       done high, one cycle only
//
// Each input transaction produces one result transaction after stages s1 to s4.
// A new transaction is taken every cycle; busy is tied low because nothing in
// the pipeline ever has to wait.
// Reset clears only the valid bits of the four stages; data registers are
// left as they are. The result side cannot stall, so done is a pure strobe.
//
// Stage map:
//   s1  twelve 16x16 products of q and v
//   s2  sums of three, round half up, keep t at 18 bits
//   s3  twelve 18x16 products of t and q
//   s4  sums of four with conjugate signs, round, saturate, flag clipping
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_top
	import qvr_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [CompW-1:0] quat_x,
	input  logic signed [CompW-1:0] quat_y,
	input  logic signed [CompW-1:0] quat_z,
	input  logic signed [CompW-1:0] quat_w,
	input  logic signed [CompW-1:0] vec_x,
	input  logic signed [CompW-1:0] vec_y,
	input  logic signed [CompW-1:0] vec_z,
	output logic                    done,
	output logic signed [CompW-1:0] out_x,
	output logic signed [CompW-1:0] out_y,
	output logic signed [CompW-1:0] out_z,
	output logic                    clipped
);

	qvr_quat_t  quat;
	qvr_vec_t   vec;
	logic       t_valid;
	qvr_tquat_t t_quat;
	qvr_quat_t  t_rot;

	// Never hold off the source: every stage advances each cycle
	assign busy = 1'b0;

	// Bundle the input ports for the product stages
	assign quat = '{x: quat_x, y: quat_y, z: quat_z, w: quat_w};
	assign vec  = '{x: vec_x, y: vec_y, z: vec_z};

	// First product: t = q * (v, 0), stages s1 and s2
	qvr_fwd_mul u_fwd (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.quat     (quat),
		.vec      (vec),
		.t_valid  (t_valid),
		.t_quat   (t_quat),
		.t_rot    (t_rot)
	);

	// Second product: r = t * conj(q), stages s3 and s4, result register
	qvr_conj_mul u_conj (
		.clk     (clk),
		.arst_n  (arst_n),
		.t_valid (t_valid),
		.t_quat  (t_quat),
		.t_rot   (t_rot),
		.r_valid (done),
		.r_x     (out_x),
		.r_y     (out_y),
		.r_z     (out_z),
		.r_clip  (clipped)
	);

endmodule
